// ===== hw/rtl/stack_engine_with_sort_core_defines.svh =====
// Assertion macros shared by the stack engine RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef STACK_ENGINE_WITH_SORT_CORE_DEFINES_SVH
`define STACK_ENGINE_WITH_SORT_CORE_DEFINES_SVH

// When the condition a holds, c must hold in the same cycle.
`define SEWS_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// When the condition a holds, c must hold in the following cycle.
`define SEWS_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// ===== hw/rtl/sews_pkg.sv =====
// Shared types, operation and status codes for the stack engine.
// No dependencies; every module of the block imports this package.
package sews_pkg;

  localparam int DEPTH_DEFAULT = 64;

  typedef logic signed [31:0] word_t;

  localparam word_t WORD_ALL_ONES = '1;

  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_POP     = 3'd1;
  localparam logic [2:0] OP_BOTTOM  = 3'd2;
  localparam logic [2:0] OP_REVERSE = 3'd3;
  localparam logic [2:0] OP_SORT    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0] operation;
    word_t      value;
  } req_t;

  typedef struct packed {
    word_t      value_out;
    logic [1:0] status;
    logic [6:0] depth_now;
  } rsp_t;

  // Address width of the word store; at least one bit.
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== hw/rtl/sews_store.sv =====
// Word store of the stack engine: one write port and one registered read port.
// Depends on sews_pkg.
module sews_store #(
  parameter int DEPTH = sews_pkg::DEPTH_DEFAULT,
  localparam int AW = sews_pkg::addr_w(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  sews_pkg::word_t   wdata,
  input  logic [AW-1:0]     raddr,
  output sews_pkg::word_t   rdata
);
  import sews_pkg::*;

  word_t mem [DEPTH];

  // A read of the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sews_ctrl.sv =====
// Sequencer of the stack engine: holds the word count, steps the store through
// each operation and drives the signed comparator of the sort. Depends on sews_pkg.
`include "stack_engine_with_sort_core_defines.svh"

module sews_ctrl #(
  parameter int DEPTH = sews_pkg::DEPTH_DEFAULT,
  localparam int AW = sews_pkg::addr_w(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        op,
  input  sews_pkg::word_t   val,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output sews_pkg::rsp_t    res,
  output logic              we,
  output logic [AW-1:0]     waddr,
  output sews_pkg::word_t   wdata,
  output logic [AW-1:0]     raddr,
  input  sews_pkg::word_t   rdata
);
  import sews_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_POP     = 4'd1;
  localparam logic [3:0] S_BOT     = 4'd2;
  localparam logic [3:0] S_BOT_FIN = 4'd3;
  localparam logic [3:0] S_REV_HI  = 4'd4;
  localparam logic [3:0] S_REV_WLO = 4'd5;
  localparam logic [3:0] S_REV_WHI = 4'd6;
  localparam logic [3:0] S_SRT_W   = 4'd7;
  localparam logic [3:0] S_SRT_CMP = 4'd8;
  localparam logic [3:0] S_SRT_PUT = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] lo, lo_next, hi, hi_next;
  logic [CW-1:0] i, i_next, j, j_next;
  word_t         w, w_next, hold, hold_next;
  word_t         res_value, res_value_next;
  logic [1:0]    res_status, res_status_next;

  logic [CW-1:0] cm1, im1, ip1, jm1, jm2;
  logic [AW:0]   lo_plus2;
  logic          full;

  assign cm1      = count - CW'(1);
  assign im1      = i - CW'(1);
  assign ip1      = i + CW'(1);
  assign jm1      = j - CW'(1);
  assign jm2      = j - CW'(2);
  assign lo_plus2 = {1'b0, lo} + (AW+1)'(2);
  assign full     = (count == CW'(DEPTH));

  always_comb begin
    state_next      = state;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    i_next          = i;
    j_next          = j;
    w_next          = w;
    hold_next       = hold;
    res_value_next  = res_value;
    res_status_next = res_status;
    we              = 1'b0;
    waddr           = '0;
    wdata           = rdata;
    raddr           = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          res_value_next  = WORD_ALL_ONES;
          res_status_next = ST_OK;
          hold_next       = val;
          state_next      = S_DONE;
          unique case (op)
            OP_PUSH: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = count[AW-1:0];
                wdata      = val;
                count_next = count + CW'(1);
              end
            end
            OP_POP: begin
              if (count == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                raddr      = cm1[AW-1:0];
                count_next = cm1;
                state_next = S_POP;
              end
            end
            OP_BOTTOM: begin
              if (full) begin
                res_status_next = ST_FULL;
              end else if (count == '0) begin
                state_next = S_BOT_FIN;
              end else begin
                j_next     = count;
                raddr      = cm1[AW-1:0];
                state_next = S_BOT;
              end
            end
            OP_REVERSE: begin
              if (count > CW'(1)) begin
                lo_next    = '0;
                hi_next    = cm1[AW-1:0];
                raddr      = '0;
                state_next = S_REV_HI;
              end
            end
            OP_SORT: begin
              if (count > CW'(1)) begin
                i_next     = CW'(1);
                raddr      = AW'(1);
                state_next = S_SRT_W;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        res_value_next = rdata;
        state_next     = S_DONE;
      end
      S_BOT: begin
        // Move the word read last cycle up by one and fetch the one below it.
        we     = 1'b1;
        waddr  = j[AW-1:0];
        wdata  = rdata;
        j_next = jm1;
        if (j == CW'(1)) begin
          state_next = S_BOT_FIN;
        end else begin
          raddr = jm2[AW-1:0];
        end
      end
      S_BOT_FIN: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = hold;
        count_next = count + CW'(1);
        state_next = S_DONE;
      end
      S_REV_HI: begin
        w_next     = rdata;
        raddr      = hi;
        state_next = S_REV_WLO;
      end
      S_REV_WLO: begin
        we         = 1'b1;
        waddr      = lo;
        wdata      = rdata;
        state_next = S_REV_WHI;
      end
      S_REV_WHI: begin
        we      = 1'b1;
        waddr   = hi;
        wdata   = w;
        lo_next = lo + AW'(1);
        hi_next = hi - AW'(1);
        raddr   = lo + AW'(1);
        if (lo_plus2 < {1'b0, hi}) begin
          state_next = S_REV_HI;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SRT_W: begin
        w_next     = rdata;
        j_next     = i;
        raddr      = im1[AW-1:0];
        state_next = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
        if (rdata < w) begin
          // The lower word is smaller, so it moves up one place.
          wdata  = rdata;
          j_next = jm1;
          if (j == CW'(1)) begin
            state_next = S_SRT_PUT;
          end else begin
            raddr = jm2[AW-1:0];
          end
        end else begin
          wdata = w;
          if (ip1 == count) begin
            state_next = S_DONE;
          end else begin
            i_next     = ip1;
            raddr      = ip1[AW-1:0];
            state_next = S_SRT_W;
          end
        end
      end
      S_SRT_PUT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = w;
        if (ip1 == count) begin
          state_next = S_DONE;
        end else begin
          i_next     = ip1;
          raddr      = ip1[AW-1:0];
          state_next = S_SRT_W;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    lo         <= lo_next;
    hi         <= hi_next;
    i          <= i_next;
    j          <= j_next;
    w          <= w_next;
    hold       <= hold_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
  end

  assign idle          = (state == S_IDLE);
  assign res_valid     = (state == S_DONE);
  assign res.value_out = res_value;
  assign res.status    = res_status;
  assign res.depth_now = 7'(count);

  `SEWS_ASSERT_NEXT(a_push_grows, start && op == OP_PUSH && !full, count == $past(count) + CW'(1), "push did not raise the count")
  `SEWS_ASSERT_NEXT(a_pop_empty, start && op == OP_POP && count == '0, res_valid && res.status == ST_EMPTY, "pop of an empty stack not flagged")
  `SEWS_ASSERT_NOW(a_waddr_range, we, waddr < DEPTH, "write beyond the store")
  `SEWS_ASSERT_NEXT(a_count_held, state != S_IDLE && state != S_BOT_FIN, count == $past(count), "count changed in the middle of an operation")

endmodule

// ===== hw/rtl/stack_engine_with_sort_core.sv =====
// Top level of the stack engine: request handshake, output register and the
// sequencer and word store below it. Depends on sews_pkg, sews_ctrl, sews_store.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------
//   in      | req_valid, req_stall, req      | operation and value
//   out     | rsp_valid, rsp_stall, rsp      | value_out, status, depth_now
//
// Requests are handled one at a time; each steps through the word store over its
// single read port. Spare operation codes change nothing and return a result.
// Reset clears the count and the sequencer; the store needs no clearing.
// A finished result waits in the output register while the next request
// is taken; the sequencer only waits when that register is still full.
module stack_engine_with_sort_core #(
  parameter int DEPTH = sews_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sews_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sews_pkg::rsp_t rsp
);
  import sews_pkg::*;

  localparam int AW = addr_w(DEPTH);

  logic          idle;
  logic          start;
  logic          res_valid;
  logic          res_ready;
  rsp_t          res;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  word_t         wdata;
  word_t         rdata;

  // A request is taken whenever the sequencer is idle.
  assign req_stall = !idle;
  assign start     = req_valid && !req_stall;

  // The output register can take a new result when it is empty or being drained.
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  sews_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (req.operation),
    .val       (req.value),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  sews_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

// ===== verif/stack_checker.sv =====
// Checker for the stack engine: it watches both channels, predicts each result
// from a private copy of the stack and compares the results field by field.
// Depends on sews_pkg for the payload types and the operation and status codes.
module stack_checker #(
  parameter int DEPTH = sews_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  sews_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  sews_pkg::rsp_t rsp,
  output int             mismatches,
  output int             waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import sews_pkg::*;

  word_t words [DEPTH];
  int    held;
  rsp_t  expected_q [$];
  int    fails;

  assign mismatches = fails;

  // Applies one request to the shadow stack and returns the result it should give.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t  res;
    word_t w;
    int    i;
    int    j;
    res.value_out = WORD_ALL_ONES;
    res.status    = ST_OK;
    case (r.operation)
      OP_PUSH: begin
        if (held >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          words[held] = r.value;
          held++;
        end
      end
      OP_POP: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          held--;
          res.value_out = words[held];
        end
      end
      OP_BOTTOM: begin
        if (held >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (j = held; j > 0; j--) words[j] = words[j-1];
          words[0] = r.value;
          held++;
        end
      end
      OP_REVERSE: begin
        for (j = 0; j < held / 2; j++) begin
          w                 = words[j];
          words[j]          = words[held-1-j];
          words[held-1-j]   = w;
        end
      end
      OP_SORT: begin
        // Largest word at the bottom entry, smallest on top.
        for (i = 1; i < held; i++) begin
          w = words[i];
          j = i;
          while (j > 0 && words[j-1] < w) begin
            words[j] = words[j-1];
            j--;
          end
          words[j] = w;
        end
      end
      default: ;
    endcase
    res.depth_now = 7'(held);
    return res;
  endfunction

  function automatic void report(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    fails++;
    $display("%0t: %s expected %h, got %h", $time, field, want, got);
  endfunction

  initial begin
    held    = 0;
    fails   = 0;
    waiting = 0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      held = 0;
      expected_q.delete();
    end else begin
      // A result accepted on the same edge as a request belongs to an older one.
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", '0, rsp.value_out);
        end else begin
          want = expected_q.pop_front();
          if (rsp.value_out !== want.value_out)
            report("value_out", want.value_out, rsp.value_out);
          if (rsp.status !== want.status)
            report("status", want.status, rsp.status);
          if (rsp.depth_now !== want.depth_now)
            report("depth_now", want.depth_now, rsp.depth_now);
        end
      end
      if (req_valid && !req_stall) expected_q.push_back(apply_request(req));
    end
    waiting = expected_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the stack engine testbench: clock, reset, request and result traffic.
// Depends on sews_pkg, stack_engine_with_sort_core and stack_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sews_pkg::*;

  // Operation codes above sort are not used by the block and must be ignored.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // Number of random requests after the directed opening.
  localparam int RANDOM_REQUESTS = 1900;
  // Window of random requests during which neither side ever idles.
  localparam int BUSY_FROM = 700;
  localparam int BUSY_TO   = 1000;
  // A full sort of 64 words runs with nothing accepted on either channel, so this
  // limit leaves a wide margin while still catching a hung block.
  localparam int QUIET_LIMIT = 20000;

  typedef enum logic [1:0] {LOAD_FILL, LOAD_DRAIN, LOAD_MIXED} load_e;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic no_idle;
  int   mismatches;
  int   waiting;

  word_t corner_words [5];

  stack_engine_with_sort_core #(
    .DEPTH(DEPTH_DEFAULT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  stack_checker #(
    .DEPTH(DEPTH_DEFAULT)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .mismatches(mismatches),
    .waiting   (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drives one request from a falling edge and holds it until it is accepted.
  // Now and then the channel is left idle first, unless the busy window is open.
  // The task returns on the falling edge after acceptance,
  // so valid is only ever assigned once per time step.
  task automatic send_request(input logic [2:0] op, input word_t val);
    if (!no_idle && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_valid     <= 1'b1;
    req.operation <= op;
    req.value     <= val;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // The result side stalls at random with a chance of 30 percent, never in the busy window.
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      rsp_stall <= !no_idle && ($urandom_range(99) < 30);
    end
  end

  // Request stimulus and the verdict.
  initial begin
    load_e       load;
    int          stint;
    int          roll;
    int          push_lim;
    int          bottom_lim;
    int          pop_lim;
    int          reverse_lim;
    int          sort_lim;
    logic [2:0]  op;
    word_t       val;

    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    no_idle   = 1'b0;
    corner_words[0] = 32'sh8000_0000;
    corner_words[1] = 32'sh7fff_ffff;
    corner_words[2] = '0;
    corner_words[3] = WORD_ALL_ONES;
    corner_words[4] = 32'sd1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening. On an empty stack a pop must report empty, while
    // reverse, sort and the spare codes change nothing.
    send_request(OP_POP, 32'sd5);
    send_request(OP_REVERSE, '0);
    send_request(OP_SORT, '0);
    for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++)
      send_request(3'(code), 32'sh1234_5678);
    // A single word: reverse and sort leave it as it is.
    send_request(OP_PUSH, 32'sh7fff_ffff);
    send_request(OP_REVERSE, '0);
    send_request(OP_SORT, '0);
    send_request(OP_POP, '0);
    // A few words at the extremes of the range, with equal words for the sort.
    send_request(OP_PUSH, 32'sh8000_0000);
    send_request(OP_PUSH, 32'sh7fff_ffff);
    send_request(OP_BOTTOM, '0);
    send_request(OP_BOTTOM, WORD_ALL_ONES);
    send_request(OP_PUSH, 32'sd1);
    send_request(OP_PUSH, WORD_ALL_ONES);
    send_request(OP_REVERSE, '0);
    send_request(OP_SORT, '0);
    send_request(OP_POP, '0);
    send_request(OP_POP, '0);
    send_request(OP_SPARE_LAST, WORD_ALL_ONES);
    send_request(OP_POP, '0);

    // Random part. The mix of operations swings between filling, draining and
    // a balanced load, so that the stack reaches both empty and full and the
    // sort and reverse see every depth in between.
    load  = LOAD_MIXED;
    stint = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (stint == 0) begin
        roll  = $urandom_range(99);
        load  = (roll < 40) ? LOAD_FILL : (roll < 70) ? LOAD_DRAIN : LOAD_MIXED;
        stint = $urandom_range(40, 120);
      end
      stint--;
      no_idle = (n >= BUSY_FROM && n < BUSY_TO);

      case (load)
        LOAD_FILL: begin
          push_lim = 45; bottom_lim = 70; pop_lim = 80; reverse_lim = 87; sort_lim = 95;
        end
        LOAD_DRAIN: begin
          push_lim = 15; bottom_lim = 20; pop_lim = 80; reverse_lim = 88; sort_lim = 95;
        end
        default: begin
          push_lim = 30; bottom_lim = 45; pop_lim = 75; reverse_lim = 85; sort_lim = 95;
        end
      endcase

      roll = $urandom_range(99);
      if (roll < push_lim)         op = OP_PUSH;
      else if (roll < bottom_lim)  op = OP_BOTTOM;
      else if (roll < pop_lim)     op = OP_POP;
      else if (roll < reverse_lim) op = OP_REVERSE;
      else if (roll < sort_lim)    op = OP_SORT;
      else                         op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));

      // Small values give the sort plenty of equal and near-equal words.
      roll = $urandom_range(99);
      if (roll < 10)      val = corner_words[$urandom_range(4)];
      else if (roll < 35) val = word_t'($urandom_range(8)) - 32'sd4;
      else                val = word_t'($urandom);

      send_request(op, val);
    end

    no_idle   = 1'b0;
    req_valid <= 1'b0;

    // Every request gives exactly one result, so once nothing is owed the
    // block can only be idle; a short settling time catches stray results.
    while (waiting != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: ends the run when nothing is accepted on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
